### rtl/ordered_list_store_assert.svh
// ----------------------------------------------------------------------------
// ordered_list_store assertion macros
// Concurrent checks clocked on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_STORE_ASSERT_SVH
`define ORDERED_LIST_STORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// expr holds at every edge out of reset
`define OLS_ASSERT(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("ordered_list_store check failed");

// cond at one edge implies prop at the next
`define OLS_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("ordered_list_store check failed");

`else

`define OLS_ASSERT(label, expr)
`define OLS_ASSERT_NEXT(label, cond, prop)

`endif

`endif

### rtl/ols_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ols_pkg
// Shared codes, widths and control types of the ordered list store.
// ----------------------------------------------------------------------------
package ols_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int OP_W    = 3;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  // wide enough for positions and counts up to a capacity of 256
  localparam int IDX_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_GET         = 3'd0,
    OP_PUT         = 3'd1,
    OP_INSERT      = 3'd2,
    OP_DELETE      = 3'd3,
    OP_APPEND      = 3'd4,
    OP_APPEND_UNIQ = 3'd5,
    OP_CLEAR       = 3'd6
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             ok;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] used;
  } ctrl_t;

endpackage
`default_nettype wire

### rtl/ols_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ols_cell
// One list slot: holds a word, shifts to or from its neighbors, reports
// match and read data.
// ----------------------------------------------------------------------------
module ols_cell
  import ols_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int CELL_IDX  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  ctrl_t                ctrl_i,
  input  logic [WORD_BITS-1:0] value_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  output logic [WORD_BITS-1:0] entry_o,
  output logic                 hit_o,
  output logic [WORD_BITS-1:0] rd_o
);

  localparam logic [IDX_W-1:0] Idx   = IDX_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] IdxP1 = IDX_W'(CELL_IDX + 1);

  logic [WORD_BITS-1:0] entry_q, entry_d;
  logic                 at_pos, below_used;

  assign at_pos     = (Idx == ctrl_i.pos);
  assign below_used = (Idx < ctrl_i.used);

  always_comb begin
    entry_d = entry_q;
    if (en_i && ctrl_i.ok) begin
      case (ctrl_i.op)
        OP_PUT: begin
          if (at_pos) entry_d = value_i;
        end
        OP_INSERT: begin
          if (at_pos) begin
            entry_d = value_i;
          end else if (Idx > ctrl_i.pos && Idx <= ctrl_i.used) begin
            entry_d = left_i;
          end
        end
        OP_DELETE: begin
          if (Idx >= ctrl_i.pos && below_used) begin
            entry_d = (IdxP1 < ctrl_i.used) ? right_i : '0;
          end
        end
        OP_APPEND, OP_APPEND_UNIQ: begin
          if (Idx == ctrl_i.used) entry_d = value_i;
        end
        OP_CLEAR: entry_d = '0;
        default:  entry_d = entry_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
  assign hit_o   = below_used && (entry_q == value_i);
  assign rd_o    = at_pos ? entry_q : '0;

endmodule
`default_nettype wire

### rtl/ordered_list_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_store
// Fixed-capacity ordered word list built as a row of slot cells.
// ----------------------------------------------------------------------------
// Each request (get, put, insert, delete, append, append unique, clear) is
// accepted when s_axis_tvalid and s_axis_tready are both high, and its result
// appears on the master side in the next cycle. All slots update together
// on accept, taking a word from the slot below on insert or from the slot
// above on delete, so a new request is taken every cycle while the result
// register is empty or being drained. The per-slot match and read lines are
// OR-reduced in the accept cycle, which sets the path length as capacity grows.
// ----------------------------------------------------------------------------
module ordered_list_store
  import ols_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // operation[2:0], position[7:3], value[39:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // ok[0], data[32:1], count[37:33], zero[39:38]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [OP_W-1:0]      op_raw;
  op_e                  op;
  logic [POS_W-1:0]     position;
  logic [VALUE_W-1:0]   value;
  logic [WORD_BITS-1:0] word;

  logic [CNT_W-1:0]     used_q, used_d;
  logic                 vld_q;
  logic                 ok_q, ok_d;
  logic [DATA_W-1:0]    data_q, data_d;
  logic [COUNT_W-1:0]   count_q;

  logic                 accept;
  logic [IDX_W-1:0]     pos_x, used_x;
  logic                 in_rng, ins_rng, full, dup;
  logic [WORD_BITS-1:0] rd_word;
  ctrl_t                ctrl;

  logic [WORD_BITS-1:0] entry_w [CAPACITY];
  logic [WORD_BITS-1:0] rd_w    [CAPACITY];
  logic [CAPACITY-1:0]  hit_w;

  assign op_raw   = s_axis_tdata[2:0];
  assign op       = op_e'(op_raw);
  assign position = s_axis_tdata[7:3];
  assign value    = s_axis_tdata[39:8];
  assign word     = WORD_BITS'(value);

  assign s_axis_tready = !vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos_x   = IDX_W'(position);
  assign used_x  = IDX_W'(used_q);
  assign in_rng  = pos_x < used_x;
  assign ins_rng = pos_x <= used_x;
  assign full    = (used_q == CNT_W'(CAPACITY));
  assign dup     = |hit_w;

  always_comb begin
    rd_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_word = rd_word | rd_w[k];
    end
  end

  always_comb begin
    ok_d   = 1'b0;
    data_d = '0;
    used_d = used_q;
    case (op)
      OP_GET: begin
        ok_d   = in_rng;
        data_d = in_rng ? DATA_W'(rd_word) : '0;
      end
      OP_PUT: ok_d = in_rng;
      OP_INSERT: begin
        ok_d = ins_rng && !full;
        if (ok_d) used_d = used_q + CNT_W'(1);
      end
      OP_DELETE: begin
        ok_d = in_rng;
        if (ok_d) begin
          used_d = used_q - CNT_W'(1);
          data_d = DATA_W'(rd_word);
        end
      end
      OP_APPEND: begin
        ok_d = !full;
        if (ok_d) used_d = used_q + CNT_W'(1);
      end
      OP_APPEND_UNIQ: begin
        ok_d = !dup && !full;
        if (ok_d) used_d = used_q + CNT_W'(1);
      end
      OP_CLEAR: begin
        ok_d   = 1'b1;
        used_d = '0;
      end
      default: ok_d = 1'b0;
    endcase
  end

  assign ctrl.op   = op;
  assign ctrl.ok   = ok_d;
  assign ctrl.pos  = pos_x;
  assign ctrl.used = used_x;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_w[k+1];
    end
    ols_cell #(
      .WORD_BITS (WORD_BITS),
      .CELL_IDX  (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (accept),
      .ctrl_i  (ctrl),
      .value_i (word),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[k]),
      .hit_o   (hit_w[k]),
      .rd_o    (rd_w[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (accept) begin
        used_q <= used_d;
        vld_q  <= 1'b1;
      end else if (m_axis_tready) begin
        vld_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q    <= ok_d;
      data_q  <= data_d;
      count_q <= COUNT_W'(used_d);
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {2'b00, count_q, data_q, ok_q};

  // assertions
  `include "ordered_list_store_assert.svh"

  `OLS_ASSERT(a_used_bound, used_q <= CNT_W'(CAPACITY))
  `OLS_ASSERT(a_fail_no_data, !vld_q || ok_q || data_q == '0)
  `OLS_ASSERT_NEXT(a_clear_empties, accept && op == OP_CLEAR, used_q == '0 && ok_q)
  `OLS_ASSERT_NEXT(a_stall_holds_count, !accept, $stable(used_q))

endmodule
`default_nettype wire
